/* hw/rtl/frs_pkg.sv */
// frs_pkg: shared types, codes and sizing constants for the filtered reservoir sampler
// no dependencies; imported by every module of the sampler
`default_nettype none

package frs_pkg;

    // default and bounds for the reservoir depth
    localparam int FRS_MAX_FANOUT   = 32;
    localparam int FRS_RESULT_LIMIT = 32;

    // field widths
    localparam int ID_W     = 64;
    localparam int TIME_W   = 64;
    localparam int RAND_W   = 64;
    localparam int SEEN_W   = 32;
    localparam int FANOUT_W = 6;
    localparam int SLOT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // input item kinds
    localparam logic KIND_CANDIDATE = 1'b0;
    localparam logic KIND_FINISH    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_USED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_USED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TIME    = 3'd4;

    localparam logic [FANOUT_W-1:0] FANOUT_RESET = 6'd8;

    // control state of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_EMPTY
    } t_state;

    // slot draw request and response
    typedef struct packed {
        logic                start;
        logic [RAND_W-1:0]   word;
        logic [SEEN_W:0]     range;
    } t_draw_req;

    typedef struct packed {
        logic                done;
        logic [RAND_W-1:0]   slot;
    } t_draw_rsp;

endpackage

`default_nettype wire

/* hw/rtl/frs_mem.sv */
// frs_mem: reservoir storage, one write port and one registered read port
// depends on frs_pkg for the identifier width
`default_nettype none

module frs_mem
    import frs_pkg::*;
#(
    parameter int DEPTH  = FRS_MAX_FANOUT,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [ID_W-1:0]   i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [ID_W-1:0]   o_rdata
);

    logic [ID_W-1:0] r_ram [DEPTH];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ram[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_ram[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/frs_slot_draw.sv */
// frs_slot_draw: high 64 bits of random word times range, one shared 32x32 multiplier
// depends on frs_pkg for the request and response structs
`default_nettype none

module frs_slot_draw
    import frs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_draw_req i_req,
    output t_draw_rsp      o_rsp
);

    localparam int HALF_W = 32;
    localparam int SUM_W  = RAND_W + SEEN_W + 1;

    logic [RAND_W-1:0]   r_a;
    logic [SEEN_W:0]     r_m;
    logic [2*HALF_W-1:0] r_p0;
    logic [2*HALF_W-1:0] r_p1;
    logic [RAND_W-1:0]   r_slot;
    logic                r_done;
    logic [1:0]          r_step;

    logic [HALF_W-1:0]   w_op;
    logic [2*HALF_W-1:0] w_prod;
    logic [SUM_W-1:0]    w_sum;

    // low half of the word on the first pass, high half on the second
    assign w_op   = (r_step == 2'd1) ? r_a[HALF_W-1:0] : r_a[RAND_W-1:HALF_W];
    assign w_prod = w_op * r_m[HALF_W-1:0];

    // range bit 32 adds the word shifted up by 32
    assign w_sum = {{(SUM_W-2*HALF_W){1'b0}}, r_p0}
                 + {1'b0, r_p1, {HALF_W{1'b0}}}
                 + (r_m[SEEN_W] ? {1'b0, r_a, {HALF_W{1'b0}}} : {SUM_W{1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == 2'd3);
            if (i_req.start) begin
                r_step <= 2'd1;
            end else if (r_step != 2'd0) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.word;
            r_m <= i_req.range;
        end
        if (r_step == 2'd1) begin
            r_p0 <= w_prod;
        end
        if (r_step == 2'd2) begin
            r_p1 <= w_prod;
        end
        if (r_step == 2'd3) begin
            r_slot <= {{(RAND_W-(SUM_W-RAND_W)){1'b0}}, w_sum[SUM_W-1:RAND_W]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.slot = r_slot;

endmodule

`default_nettype wire

/* hw/rtl/filtered_reservoir_sampler_unit.sv */
// filtered_reservoir_sampler_unit: temporal filter and algorithm r reservoir over one neighbour list
// a dropped candidate or one that fills a free slot is taken in the idle state; a candidate meeting a
//   full reservoir stalls the input through two passes of the shared slot-draw multiplier, the sum
//   of the partial products and the write-back
// finish: each kept slot is read from the memory, then loaded into the output register, or the
//   single empty result is loaded; output stalls hold both
// reset: synchronous, active low; control and configuration clear, payload and reservoir undefined
// depends on frs_pkg, frs_mem, frs_slot_draw
`default_nettype none

module filtered_reservoir_sampler_unit
    import frs_pkg::*;
#(
    parameter int MAX_FANOUT = FRS_MAX_FANOUT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    // configuration writes
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,

    // input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_kind,
    input  wire logic [ID_W-1:0]         i_neighbor_id,
    input  wire logic                    i_start_null,
    input  wire logic signed [TIME_W-1:0] i_start_time,
    input  wire logic                    i_end_null,
    input  wire logic signed [TIME_W-1:0] i_end_time,
    input  wire logic [RAND_W-1:0]       i_random_word,

    // output channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [ID_W-1:0]              o_sample_id,
    output logic [SLOT_W-1:0]            o_sample_slot,
    output logic                         o_sample_valid,
    output logic [SEEN_W-1:0]            o_seen_total,
    output logic                         o_last
);

    // address width of the reservoir, at least one bit
    localparam int IDX_W = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
    // slots that can really be used
    localparam int LIMIT = (MAX_FANOUT < FRS_RESULT_LIMIT) ? MAX_FANOUT : FRS_RESULT_LIMIT;
    localparam logic [FANOUT_W-1:0] LIMIT_V = FANOUT_W'(LIMIT);

    // configuration registers
    logic [FANOUT_W-1:0]      r_fanout;
    logic                     r_filter_en;
    logic                     r_start_used;
    logic                     r_end_used;
    logic signed [TIME_W-1:0] r_query_time;

    // control state
    t_state              r_state, n_state;
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [FANOUT_W-1:0] r_fill, n_fill;
    logic [FANOUT_W-1:0] r_k, n_k;
    logic [ID_W-1:0]     r_id, n_id;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic                r_out_sval, n_out_sval;
    logic [SEEN_W-1:0]   r_out_seen, n_out_seen;
    logic                r_out_last, n_out_last;

    // reservoir port controls
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ID_W-1:0]  w_wdata;
    logic             w_re;
    logic [ID_W-1:0]  w_rdata;

    t_draw_req w_draw_req;
    t_draw_rsp w_draw_rsp;

    logic [FANOUT_W-1:0] w_eff;
    logic                w_in_acc;
    logic                w_pass;
    logic                w_out_free;
    logic [SEEN_W-1:0]   w_seen_inc;
    logic [SEEN_W-1:0]   w_eff_wide;
    logic [RAND_W-1:0]   w_eff_slot;
    logic [RAND_W-1:0]   w_fill_slot;

    // fanout limited by the reservoir depth and the result run length
    assign w_eff      = (r_fanout > LIMIT_V) ? LIMIT_V : r_fanout;
    assign w_eff_wide = {{(SEEN_W-FANOUT_W){1'b0}}, w_eff};
    assign w_eff_slot = {{(RAND_W-FANOUT_W){1'b0}}, w_eff};
    assign w_fill_slot = {{(RAND_W-FANOUT_W){1'b0}}, r_fill};

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // seen counter stops at all ones
    assign w_seen_inc = (r_seen == {SEEN_W{1'b1}}) ? r_seen : r_seen + 1'b1;

    // temporal filter: not yet valid, or already ended at the query time
    always_comb begin
        w_pass = 1'b1;
        if (r_filter_en) begin
            if (r_start_used && !i_start_null && (r_query_time < i_start_time)) begin
                w_pass = 1'b0;
            end
            if (r_end_used && !i_end_null && !(r_query_time < i_end_time)) begin
                w_pass = 1'b0;
            end
        end
    end

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fanout     <= FANOUT_RESET;
            r_filter_en  <= 1'b0;
            r_start_used <= 1'b0;
            r_end_used   <= 1'b0;
            r_query_time <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FANOUT:        r_fanout     <= i_cfg_data[FANOUT_W-1:0];
                CFG_FILTER_ENABLE: r_filter_en  <= i_cfg_data[0];
                CFG_START_USED:    r_start_used <= i_cfg_data[0];
                CFG_END_USED:      r_end_used   <= i_cfg_data[0];
                CFG_QUERY_TIME:    r_query_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_fill      = r_fill;
        n_k         = r_k;
        n_id        = r_id;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_id    = r_out_id;
        n_out_slot  = r_out_slot;
        n_out_sval  = r_out_sval;
        n_out_seen  = r_out_seen;
        n_out_last  = r_out_last;

        w_we    = 1'b0;
        w_waddr = r_fill[IDX_W-1:0];
        w_wdata = i_neighbor_id;
        w_re    = 1'b0;

        w_draw_req.start = 1'b0;
        w_draw_req.word  = i_random_word;
        w_draw_req.range = {1'b0, r_seen} + 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_kind == KIND_FINISH) begin
                        n_k     = '0;
                        n_state = (r_fill == '0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
                    end else if (w_pass) begin
                        n_seen = w_seen_inc;
                        if (r_seen < w_eff_wide) begin
                            // still filling: append
                            if (r_fill < w_eff) begin
                                w_we   = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end else begin
                            // full: draw a slot for possible replacement
                            w_draw_req.start = 1'b1;
                            n_id             = i_neighbor_id;
                            n_state          = ST_DRAW;
                        end
                    end
                end
            end

            ST_DRAW: begin
                w_waddr = w_draw_rsp.slot[IDX_W-1:0];
                w_wdata = r_id;
                if (w_draw_rsp.done) begin
                    if ((w_draw_rsp.slot < w_eff_slot) && (w_draw_rsp.slot < w_fill_slot)) begin
                        w_we = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end

            ST_EMIT_RD: begin
                w_re    = 1'b1;
                n_state = ST_EMIT_LD;
            end

            ST_EMIT_LD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = w_rdata;
                    n_out_slot  = r_k[SLOT_W-1:0];
                    n_out_sval  = 1'b1;
                    n_out_seen  = r_seen;
                    n_out_last  = (r_k + 1'b1 == r_fill);
                    if (r_k + 1'b1 == r_fill) begin
                        // run complete, start a new list
                        n_seen  = '0;
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end

            ST_EMIT_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = '0;
                    n_out_slot  = '0;
                    n_out_sval  = 1'b0;
                    n_out_seen  = r_seen;
                    n_out_last  = 1'b1;
                    n_seen      = '0;
                    n_fill      = '0;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_out_id   <= n_out_id;
        r_out_slot <= n_out_slot;
        r_out_sval <= n_out_sval;
        r_out_seen <= n_out_seen;
        r_out_last <= n_out_last;
    end

    frs_mem #(
        .DEPTH  (MAX_FANOUT),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    frs_slot_draw u_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_draw_req),
        .o_rsp   (w_draw_rsp)
    );

    assign o_out_valid    = r_out_valid;
    assign o_sample_id    = r_out_id;
    assign o_sample_slot  = r_out_slot;
    assign o_sample_valid = r_out_sval;
    assign o_seen_total   = r_out_seen;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

/* dv/tb_filtered_reservoir_sampler_unit.sv */
// testbench for filtered_reservoir_sampler_unit: directed filter, fanout and mid-list cases,
// then random neighbour lists checked against an in-bench reservoir predictor
// depends on frs_pkg and the sampler rtl only
`timescale 1ns / 1ps

module tb_filtered_reservoir_sampler_unit;
    import frs_pkg::*;

    localparam int  RANDOM_ITEMS = 440;
    localparam int  IDLE_CYCLES  = 12;     // covers a full-reservoir slot draw
    localparam int  DRAIN_LIMIT  = 50000;
    localparam int  TAIL_CYCLES  = 20;
    localparam longint TIMEOUT_NS = 20_000_000;

    // ring of expected samples, deeper than the longest run
    localparam int  EXP_AW    = 6;
    localparam int  EXP_DEPTH = 1 << EXP_AW;

    // out-of-range register index, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic signed [TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic                     kind;
        logic [ID_W-1:0]          nid;
        logic                     snull;
        logic signed [TIME_W-1:0] st;
        logic                     enull;
        logic signed [TIME_W-1:0] et;
        logic [RAND_W-1:0]        rw;
    } t_item;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic              valid;
        logic [SEEN_W-1:0] seen;
        logic              last;
    } t_sample;

    // clock, reset and block inputs, all known from time zero
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     i_kind = KIND_CANDIDATE;
    logic [ID_W-1:0]          i_neighbor_id = '0;
    logic                     i_start_null = 1'b0;
    logic signed [TIME_W-1:0] i_start_time = '0;
    logic                     i_end_null = 1'b0;
    logic signed [TIME_W-1:0] i_end_time = '0;
    logic [RAND_W-1:0]        i_random_word = '0;
    logic                     i_out_stall = 1'b0;

    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [ID_W-1:0]          o_sample_id;
    logic [SLOT_W-1:0]        o_sample_slot;
    logic                     o_sample_valid;
    logic [SEEN_W-1:0]        o_seen_total;
    logic                     o_last;

    // predictor state: configuration copy, counters and the reservoir itself
    logic [FANOUT_W-1:0]      fanout_r;
    logic                     filt_en;
    logic                     start_used;
    logic                     end_used;
    logic signed [TIME_W-1:0] query_t;
    logic [SEEN_W-1:0]        seen_cnt;
    int                       fill_cnt;
    logic [ID_W-1:0]          kept_ids [FRS_MAX_FANOUT];

    t_sample exp_fifo [EXP_DEPTH];
    int      exp_wr = 0;
    int      exp_rd = 0;
    int      mismatch_count = 0;
    int      items_sent = 0;
    bit      no_idle = 1'b0;

    filtered_reservoir_sampler_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_neighbor_id  (i_neighbor_id),
        .i_start_null   (i_start_null),
        .i_start_time   (i_start_time),
        .i_end_null     (i_end_null),
        .i_end_time     (i_end_time),
        .i_random_word  (i_random_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_id    (o_sample_id),
        .o_sample_slot  (o_sample_slot),
        .o_sample_valid (o_sample_valid),
        .o_seen_total   (o_seen_total),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int pending_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic void queue_sample(input t_sample s);
        exp_fifo[exp_wr[EXP_AW-1:0]] = s;
        exp_wr++;
    endfunction

    function automatic int eff_fanout();
        return (fanout_r > FRS_MAX_FANOUT) ? FRS_MAX_FANOUT : int'(fanout_r);
    endfunction

    // temporal validity: drop if query is before a present start, or at/after a present end
    function automatic bit keeps(input t_item it);
        if (!filt_en)
            return 1'b1;
        if (start_used && !it.snull && (query_t < it.st))
            return 1'b0;
        if (end_used && !it.enull && !(query_t < it.et))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic reset_model();
        fanout_r   = FANOUT_RESET;
        filt_en    = 1'b0;
        start_used = 1'b0;
        end_used   = 1'b0;
        query_t    = '0;
        seen_cnt   = '0;
        fill_cnt   = 0;
    endtask

    // updates the reservoir for one accepted transfer, queues any samples it emits
    task automatic reservoir_accept(input t_item it);
        int           eff;
        logic [127:0] prod;
        logic [63:0]  j;
        t_sample      s;
        eff = eff_fanout();
        if (it.kind == KIND_CANDIDATE) begin
            if (!keeps(it))
                return;
            if (seen_cnt < eff) begin
                // still filling: append while there is room
                if (fill_cnt < eff) begin
                    kept_ids[fill_cnt[SLOT_W-1:0]] = it.nid;
                    fill_cnt++;
                end
            end else begin
                // algorithm r: slot is the high half of word * (seen + 1)
                prod = 128'(it.rw) * (128'(seen_cnt) + 128'd1);
                j    = prod[127:64];
                if (j < eff && j < fill_cnt)
                    kept_ids[j[SLOT_W-1:0]] = it.nid;
            end
            if (seen_cnt != '1)
                seen_cnt++;
        end else begin
            if (fill_cnt == 0) begin
                s = '{id: '0, slot: '0, valid: 1'b0, seen: seen_cnt, last: 1'b1};
                queue_sample(s);
            end else begin
                for (int k = 0; k < fill_cnt; k++) begin
                    s = '{id: kept_ids[SLOT_W'(k)], slot: SLOT_W'(k), valid: 1'b1,
                          seen: seen_cnt, last: (k == fill_cnt - 1)};
                    queue_sample(s);
                end
            end
            seen_cnt = '0;
            fill_cnt = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle cycles before the next transfer, zero throughout burst stretches
    function automatic int pick_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic t_item cand(input logic [ID_W-1:0] nid, input logic snull,
                                   input logic signed [TIME_W-1:0] st, input logic enull,
                                   input logic signed [TIME_W-1:0] et,
                                   input logic [RAND_W-1:0] rw);
        t_item it;
        it = '{kind: KIND_CANDIDATE, nid: nid, snull: snull, st: st, enull: enull, et: et,
               rw: rw};
        return it;
    endfunction

    function automatic t_item finish_item();
        t_item it;
        it = '{kind: KIND_FINISH, nid: {$urandom, $urandom}, snull: 1'($urandom_range(0, 1)),
               st: {$urandom, $urandom}, enull: 1'($urandom_range(0, 1)),
               et: {$urandom, $urandom}, rw: {$urandom, $urandom}};
        return it;
    endfunction

    // times cluster around the query so both sides of each bound get hit
    function automatic logic signed [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return TIME_MIN;
            1:       return TIME_MAX;
            2, 3:    return query_t + 64'($urandom_range(0, 6)) - 64'd3;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_item random_candidate();
        logic [RAND_W-1:0] rw;
        case ($urandom_range(0, 7))
            0:       rw = '0;
            1:       rw = '1;
            default: rw = {$urandom, $urandom};
        endcase
        return cand({$urandom, $urandom}, 1'($urandom_range(0, 1)), pick_time(),
                    1'($urandom_range(0, 1)), pick_time(), rw);
    endfunction

    // one transfer on the input channel; valid is left high for a back-to-back follow-up
    task automatic send_item(input t_item it);
        int gap;
        gap = pick_wait();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= it.kind;
        i_neighbor_id <= it.nid;
        i_start_null  <= it.snull;
        i_start_time  <= it.st;
        i_end_null    <= it.enull;
        i_end_time    <= it.et;
        i_random_word <= it.rw;
        do @(posedge i_clk); while (o_in_stall);
        reservoir_accept(it);
        items_sent++;
    endtask

    // sender holds off until every queued sample has been transferred
    task automatic wait_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count() != 0)
            @(posedge i_clk);
    endtask

    // quiet point for register writes: candidates may still be drawing a slot
    task automatic wait_idle();
        wait_results();
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_FANOUT:        fanout_r   = data[FANOUT_W-1:0];
            CFG_FILTER_ENABLE: filt_en    = data[0];
            CFG_START_USED:    start_used = data[0];
            CFG_END_USED:      end_used   = data[0];
            CFG_QUERY_TIME:    query_t    = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // output side: random stall and checking
    // ------------------------------------------------------------------

    // stall drawn afresh for each result transfer
    initial begin : result_stall
        int n;
        forever begin
            n = pick_wait();
            @(negedge i_clk);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_count() == 0) begin
                $display("%0t ns: unexpected sample, expected none actual id %0h slot %0d",
                         $time, o_sample_id, o_sample_slot);
                mismatch_count++;
            end else begin
                s = exp_fifo[exp_rd[EXP_AW-1:0]];
                exp_rd++;
                check_field("sample_id", s.id, o_sample_id);
                check_field("sample_slot", 64'(s.slot), 64'(o_sample_slot));
                check_field("sample_valid", 64'(s.valid), 64'(o_sample_valid));
                check_field("seen_total", 64'(s.seen), 64'(o_seen_total));
                check_field("last", 64'(s.last), 64'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: empty finish first, then a short list under the default fanout
    task automatic test_reset_defaults();
        send_item(finish_item());
        for (int i = 0; i < 3; i++)
            send_item(cand({$urandom, $urandom}, 1'b0, TIME_MAX, 1'b0, TIME_MIN, '1));
        send_item(finish_item());
    endtask

    // both bounds at and around the query, nulls, extremes, and bounds switched off
    task automatic test_filter_bounds();
        wait_idle();
        write_reg(CFG_FILTER_ENABLE, 64'd1);
        write_reg(CFG_START_USED, 64'd1);
        write_reg(CFG_END_USED, 64'd1);
        write_reg(CFG_QUERY_TIME, 64'd1000);
        write_reg(CFG_UNUSED, '1);
        send_item(cand(64'h11, 1'b0, 64'sd1000, 1'b0, 64'sd1001, '0));  // start at query kept
        send_item(cand(64'h12, 1'b0, 64'sd1001, 1'b1, TIME_MIN, '0));   // start after query
        send_item(cand(64'h13, 1'b1, TIME_MAX, 1'b1, TIME_MIN, '0));    // both absent
        send_item(cand(64'h14, 1'b0, TIME_MIN, 1'b0, 64'sd1000, '0));   // end at query drops
        send_item(cand(64'h15, 1'b0, TIME_MIN, 1'b0, TIME_MAX, '0));
        send_item(cand(64'h16, 1'b0, 64'sd999, 1'b0, TIME_MIN, '0));
        wait_idle();
        write_reg(CFG_START_USED, 64'd0);
        send_item(cand(64'h17, 1'b0, TIME_MAX, 1'b1, 64'sd0, '0));      // start ignored
        wait_idle();
        write_reg(CFG_FILTER_ENABLE, 64'd0);
        send_item(cand(64'h18, 1'b0, TIME_MAX, 1'b0, TIME_MIN, '0));    // filter off
        send_item(finish_item());
    endtask

    // fanout zero keeps nothing but still counts survivors
    task automatic test_fanout_zero();
        wait_idle();
        write_reg(CFG_FANOUT, 64'd0);
        send_item(random_candidate());
        send_item(random_candidate());
        send_item(finish_item());
    endtask

    // reservoir full at fanout 2, then fanout raised with the list still open
    task automatic test_fanout_midlist();
        wait_idle();
        write_reg(CFG_FANOUT, 64'd2);
        send_item(cand(64'hA0, 1'b1, '0, 1'b1, '0, '0));
        send_item(cand(64'hA1, 1'b1, '0, 1'b1, '0, '0));
        send_item(cand(64'hA2, 1'b1, '0, 1'b1, '0, '1));   // draw lands past the reservoir
        send_item(cand(64'hA3, 1'b1, '0, 1'b1, '0, '0));   // draw lands on slot zero
        wait_idle();
        write_reg(CFG_FANOUT, 64'd6);
        send_item(cand(64'hA4, 1'b1, '0, 1'b1, '0, '1));   // appended at the next free slot
        send_item(finish_item());
    endtask

    // well-formed lists under random settings, with stray finishes and open lists
    task automatic test_random_lists();
        int phase;
        int eff;
        int len;
        int n_lists;
        phase      = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            case (phase)
                0:       write_reg(CFG_FANOUT, 64'd32);
                1:       write_reg(CFG_FANOUT, 64'd63);
                2:       write_reg(CFG_FANOUT, 64'd0);
                3:       write_reg(CFG_FANOUT, 64'd1);
                default: write_reg(CFG_FANOUT, ($urandom_range(0, 7) == 0) ?
                                   64'($urandom_range(0, 63)) : 64'($urandom_range(0, 10)));
            endcase
            write_reg(CFG_FILTER_ENABLE, {$urandom, $urandom});
            write_reg(CFG_START_USED, {$urandom, $urandom});
            write_reg(CFG_END_USED, {$urandom, $urandom});
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_QUERY_TIME, TIME_MIN);
                1:       write_reg(CFG_QUERY_TIME, TIME_MAX);
                2:       write_reg(CFG_QUERY_TIME, 64'd0);
                default: write_reg(CFG_QUERY_TIME, {$urandom, $urandom});
            endcase
            eff     = eff_fanout();
            n_lists = $urandom_range(1, 4);
            for (int l = 0; l < n_lists && items_sent < RANDOM_ITEMS; l++) begin
                len = (eff >= 16) ? $urandom_range(eff, eff + 10) : $urandom_range(0, 3 * eff + 4);
                for (int i = 0; i < len && items_sent < RANDOM_ITEMS; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(finish_item());
                    else
                        send_item(random_candidate());
                end
                // last list sometimes left open across the next register change
                if (l != n_lists - 1 || $urandom_range(0, 3) != 0)
                    send_item(finish_item());
                if ($urandom_range(0, 5) == 0)
                    wait_results();
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence and end of run
    // ------------------------------------------------------------------

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_filter_bounds();
        test_fanout_zero();
        test_fanout_midlist();
        test_random_lists();

        // drain what is still in flight, then allow for the block's own latency
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && pending_count() != 0; c++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_count() != 0) begin
            $display("%0t ns: %0d samples expected but never transferred", $time,
                     pending_count());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: timeout", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
